// File: sv/qf_pkg.sv
package qf_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ELEM_W  = 8;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned COUNT_W = 9;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

  localparam logic [COUNT_W-1:0] MERGES_SAT    = 9'd511;
  localparam logic [COUNT_W-1:0] COUNT_AT_RST  = 9'd256;

  typedef struct packed {
    logic [COUNT_W-1:0] block_count;
    logic               same_class;
    logic [LABEL_W-1:0] second_label;
    logic [LABEL_W-1:0] first_label;
    logic               index_error;
  } qf_result_t;

endpackage

// File: sv/qf_label_ram.sv
module qf_label_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/qf_ctrl.sv
module qf_ctrl #(
  parameter int unsigned MAX_ELEMENTS = 256,
  localparam int unsigned LW = $clog2(MAX_ELEMENTS),
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [qf_pkg::CMD_W-1:0]     cmd_i,
  input  logic [qf_pkg::ELEM_W-1:0]    first_i,
  input  logic [qf_pkg::ELEM_W-1:0]    second_i,
  input  logic [qf_pkg::COUNT_W-1:0]   active_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output qf_pkg::qf_result_t           res_o,
  output logic                         rd_en_o,
  output logic [LW-1:0]                rd_addr_o,
  input  logic [LW-1:0]                rd_data_i,
  output logic                         wr_en_o,
  output logic [LW-1:0]                wr_addr_o,
  output logic [LW-1:0]                wr_data_o
);
  import qf_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD_B  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [CW-1:0] CNT_END  = CW'(MAX_ELEMENTS);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_ELEMENTS - 1);

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [COUNT_W-1:0] merges_q, merges_d;
  logic               post_clear_q, post_clear_d;
  logic               is_merge_q, is_merge_d;
  logic [LW-1:0]      la_q, la_d;
  logic [LW-1:0]      lb_q, lb_d;
  logic [LW-1:0]      b_addr_q, b_addr_d;
  logic               same_q, same_d;
  logic               err_q, err_d;
  logic               accept;
  logic               err_in;
  logic [CW-1:0]      cnt_m1;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign err_in     = ({1'b0, first_i} >= active_i) || ({1'b0, second_i} >= active_i);
  assign cnt_m1     = cnt_q - 1'b1;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    merges_d     = merges_q;
    post_clear_d = post_clear_q;
    is_merge_d   = is_merge_q;
    la_d         = la_q;
    lb_d         = lb_q;
    b_addr_d     = b_addr_q;
    same_d       = same_q;
    err_d        = err_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = cnt_q[LW-1:0];
    wr_en_o      = 1'b0;
    wr_addr_o    = cnt_q[LW-1:0];
    wr_data_o    = cnt_q[LW-1:0];
    res_valid_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        // write each entry with its own index
        wr_en_o = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d      = post_clear_q ? ST_DONE : ST_IDLE;
          post_clear_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          la_d   = '0;
          lb_d   = '0;
          same_d = 1'b0;
          err_d  = 1'b0;
          if (cmd_i == CMD_REINIT) begin
            cnt_d        = '0;
            merges_d     = '0;
            post_clear_d = 1'b1;
            state_d      = ST_CLEAR;
          end else if (err_in) begin
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            rd_en_o    = 1'b1;
            rd_addr_o  = LW'(first_i);
            b_addr_d   = LW'(second_i);
            is_merge_d = (cmd_i == CMD_MERGE);
            state_d    = ST_RD_B;
          end
        end
      end
      ST_RD_B: begin
        rd_en_o   = 1'b1;
        rd_addr_o = b_addr_q;
        la_d      = rd_data_i;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        lb_d   = rd_data_i;
        same_d = (la_q == rd_data_i);
        if (is_merge_q && (la_q != rd_data_i)) begin
          cnt_d   = '0;
          state_d = ST_WALK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WALK: begin
        // read entry cnt, relabel entry cnt-1 from the data read last cycle
        if (cnt_q != CNT_END) begin
          rd_en_o   = 1'b1;
          rd_addr_o = cnt_q[LW-1:0];
        end
        if (cnt_q != '0) begin
          wr_en_o   = (rd_data_i == lb_q);
          wr_addr_o = cnt_m1[LW-1:0];
          wr_data_o = la_q;
        end
        if (cnt_q == CNT_END) begin
          if (merges_q != MERGES_SAT) begin
            merges_d = merges_q + 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      merges_q     <= '0;
      post_clear_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      merges_q     <= merges_d;
      post_clear_q <= post_clear_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_merge_q <= is_merge_d;
    la_q       <= la_d;
    lb_q       <= lb_d;
    b_addr_q   <= b_addr_d;
    same_q     <= same_d;
    err_q      <= err_d;
  end

  always_comb begin
    res_o.first_label  = LABEL_W'(la_q);
    res_o.second_label = LABEL_W'(lb_q);
    res_o.same_class   = same_q;
    res_o.index_error  = err_q;
    res_o.block_count  = (merges_q >= active_i) ? '0 : (active_i - merges_q);
  end

`ifndef SYNTH
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en_o && wr_en_o && (rd_addr_o == wr_addr_o)))
    else $error("read and write hit the same entry");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> ((state_q == ST_WALK) || (state_q == ST_CLEAR)))
    else $error("table written outside a sweep");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && err_q) |-> (!same_q && (la_q == '0) && (lb_q == '0)))
    else $error("index error result carries label data");

  a_merge_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && cnt_q == CNT_END && merges_q != MERGES_SAT)
      |=> (merges_q == $past(merges_q) + 1'b1))
    else $error("merge count not advanced after walk");
`endif

endmodule

// File: sv/quick_find_disjoint_set.sv
// Query: an accepted item passes ST_RD_B and ST_CMP before the result is valid in ST_DONE;
// an index error goes straight to ST_DONE. A merge of two distinct classes adds the
// relabel walk over the label memory, one entry per cycle; reinitialize runs the clear.
// One item is in work at a time; the output register lets the next item start
// while a result waits. Reset (async, active low) starts a clearing pass that writes
// each label with its own index; no item is taken then.
module quick_find_disjoint_set #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,   // element_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] first_element, [15:8] second_element
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] first_label, [15:8] second_label, [16] same_class, [25:17] block_count
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser   // [0] index_error
);
  import qf_pkg::*;

  localparam int unsigned LW = $clog2(MAX_ELEMENTS);

  logic [COUNT_W-1:0] element_count_q;
  logic [COUNT_W-1:0] active;
  logic               res_valid;
  logic               res_ready;
  qf_result_t         res;
  logic               out_valid_q;
  qf_result_t         out_res_q;
  logic               rd_en, wr_en;
  logic [LW-1:0]      rd_addr, rd_data, wr_addr, wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= COUNT_AT_RST;
    end else if (cfg_we_i) begin
      element_count_q <= cfg_wdata_i;
    end
  end

  // clamp the programmed count to the table size
  assign active = (32'(element_count_q) > MAX_ELEMENTS) ? COUNT_W'(MAX_ELEMENTS)
                                                        : element_count_q;

  qf_label_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (LW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  qf_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .first_i     (s_axis_tdata[7:0]),
    .second_i    (s_axis_tdata[15:8]),
    .active_i    (active),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.block_count, out_res_q.same_class,
                          out_res_q.second_label, out_res_q.first_label};
  assign m_axis_tuser  = out_res_q.index_error;

endmodule

// File: bench/qf_checker.sv
module qf_checker #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [qf_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,
  input  logic [qf_pkg::CMD_W-1:0]   s_axis_tuser,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [31:0]                m_axis_tdata,
  input  logic                       m_axis_tuser,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qf_pkg::*;

  logic [LABEL_W-1:0] class_label [MAX_ELEMENTS];
  logic [COUNT_W-1:0] merge_total;
  logic [COUNT_W-1:0] element_count;
  qf_result_t         partition_results_q [$];
  qf_result_t         want;
  int unsigned        mismatch_total;

  function automatic void relabel_singletons();
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      class_label[k] = LABEL_W'(k);
    end
    merge_total = '0;
  endfunction

  // Update the partition for one transaction and return the result it produces.
  function automatic qf_result_t apply_partition_op(input logic [CMD_W-1:0]  cmd,
                                                    input logic [ELEM_W-1:0] first_idx,
                                                    input logic [ELEM_W-1:0] second_idx);
    qf_result_t         res;
    logic [COUNT_W-1:0] active;
    logic [LABEL_W-1:0] first_lbl;
    logic [LABEL_W-1:0] second_lbl;
    res = '0;
    active = (element_count > COUNT_W'(MAX_ELEMENTS)) ? COUNT_W'(MAX_ELEMENTS) : element_count;
    if (cmd == CMD_REINIT) begin
      relabel_singletons();
    end else if ({1'b0, first_idx} >= active || {1'b0, second_idx} >= active) begin
      res.index_error = 1'b1;
    end else begin
      first_lbl = class_label[first_idx];
      second_lbl = class_label[second_idx];
      res.first_label = first_lbl;
      res.second_label = second_lbl;
      res.same_class = (first_lbl == second_lbl);
      if (cmd == CMD_MERGE && first_lbl != second_lbl) begin
        // walk the whole table, also entries above the active count
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
          if (class_label[k] == second_lbl) begin
            class_label[k] = first_lbl;
          end
        end
        if (merge_total != MERGES_SAT) begin
          merge_total = merge_total + 1'b1;
        end
      end
    end
    res.block_count = (merge_total >= active) ? '0 : active - merge_total;
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned expected_val,
                             input int unsigned actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, actual %0d", field, expected_val, actual_val);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relabel_singletons();
      element_count = COUNT_AT_RST;
      partition_results_q.delete();
      mismatch_total = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (partition_results_q.size() == 0) begin
          $error("result transaction with nothing pending: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          mismatch_total++;
        end else begin
          want = partition_results_q.pop_front();
          check_field("first_label", want.first_label, m_axis_tdata[7:0]);
          check_field("second_label", want.second_label, m_axis_tdata[15:8]);
          check_field("same_class", want.same_class, m_axis_tdata[16]);
          check_field("block_count", want.block_count, m_axis_tdata[25:17]);
          check_field("index_error", want.index_error, m_axis_tuser);
        end
      end
      if (cfg_we_i) begin
        element_count = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        partition_results_q.insert(partition_results_q.size(),
                                   apply_partition_op(s_axis_tuser, s_axis_tdata[7:0],
                                                      s_axis_tdata[15:8]));
      end
      pending_o <= partition_results_q.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qf_pkg::*;

  localparam int unsigned MAX_ELEMENTS = 256;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = MAX_ELEMENTS + 40;
  localparam int unsigned NUM_PHASES = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;
  logic [CMD_W-1:0]   s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending_n;
  int unsigned cycle_count = 0;
  int unsigned active_n;
  bit          calm;

  // count, item total and no-idle flag of each random phase
  int unsigned phase_count [NUM_PHASES] = '{256, 7, 64, 2, 256, 1, 180, 300, 0, 16};
  int unsigned phase_items [NUM_PHASES] = '{400, 150, 250, 100, 300, 50, 250, 150, 30, 170};
  bit          phase_calm  [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0, 0, 0};

  quick_find_disjoint_set #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  qf_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_n)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 30);
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= !idle_now();
  end

  // Hold valid until the transaction is taken; valid is left high when the task returns.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] first_idx,
                           input logic [ELEM_W-1:0] second_idx);
    @(negedge clk_i);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {second_idx, first_idx};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_n != 0) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    active_n = (32'(value) > MAX_ELEMENTS) ? MAX_ELEMENTS : 32'(value);
  endtask

  task automatic change_count(input logic [COUNT_W-1:0] value);
    drain_results();
    write_count(value);
  endtask

  function automatic logic [ELEM_W-1:0] pick_index();
    if (active_n > 0 && $urandom_range(99) < 90) begin
      return ELEM_W'($urandom_range(active_n - 1));
    end
    return ELEM_W'($urandom_range(255));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) begin
      return CMD_QUERY;
    end else if (roll < 88) begin
      return CMD_MERGE;
    end else if (roll < 94) begin
      return CMD_REINIT;
    end
    return CMD_SPARE;
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_QUERY;
    calm = 1'b0;
    active_n = MAX_ELEMENTS;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default count of 256
    send_item(CMD_QUERY, 8'd0, 8'd0);
    send_item(CMD_QUERY, 8'd255, 8'd0);
    send_item(CMD_MERGE, 8'd0, 8'd1);
    send_item(CMD_MERGE, 8'd1, 8'd0);
    send_item(CMD_MERGE, 8'd255, 8'd254);
    send_item(CMD_MERGE, 8'd254, 8'd0);
    send_item(CMD_QUERY, 8'd1, 8'd255);
    send_item(CMD_SPARE, 8'd2, 8'd3);
    send_item(CMD_REINIT, 8'd255, 8'd255);
    send_item(CMD_QUERY, 8'd0, 8'd1);
    send_item(CMD_MERGE, 8'd10, 8'd11);
    send_item(CMD_MERGE, 8'd12, 8'd13);
    send_item(CMD_MERGE, 8'd14, 8'd15);
    // more merges than elements after lowering the count
    change_count(9'd2);
    send_item(CMD_QUERY, 8'd0, 8'd1);
    send_item(CMD_QUERY, 8'd2, 8'd0);
    send_item(CMD_MERGE, 8'd0, 8'd1);
    change_count(9'd0);
    send_item(CMD_QUERY, 8'd0, 8'd0);
    send_item(CMD_MERGE, 8'd0, 8'd0);
    send_item(CMD_REINIT, 8'd0, 8'd0);
    change_count(9'd511);
    send_item(CMD_QUERY, 8'd255, 8'd255);
    send_item(CMD_MERGE, 8'd255, 8'd0);
    change_count(9'd1);
    send_item(CMD_QUERY, 8'd0, 8'd0);
    send_item(CMD_QUERY, 8'd0, 8'd1);
    send_item(CMD_MERGE, 8'd0, 8'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      change_count(COUNT_W'(phase_count[p]));
      calm = phase_calm[p];
      for (int i = 0; i < phase_items[p]; i++) begin
        // pause the sender once mid-phase until every result is back
        if (p == 4 && i == phase_items[p] / 2) begin
          drain_results();
        end
        send_item(pick_command(), pick_index(), pick_index());
      end
      calm = 1'b0;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_n == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
